// ===== hw/rtl/utrb_pkg.sv =====
// ----------------------------------------------------------------------------
// utrb_pkg
// Shared types and codes for the buffered serial front end: command and
// status codes, request and result structs, controller command struct.
// ----------------------------------------------------------------------------
package utrb_pkg;

  // default ring depths
  localparam int TX_DEPTH_DEF = 32;
  localparam int RX_DEPTH_DEF = 32;

  // field widths
  localparam int CMD_W  = 3;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 3;
  localparam int FILL_W = 6;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_TX  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP_RX   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LINE_RX  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LINE_RDY = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEND_EN  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_TX_FULL  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_RX_EMPTY = 3'd2;
  localparam logic [STAT_W-1:0] STAT_RX_OVFL  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NO_SEND  = 3'd4;

  // one request
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_byte;
  } utrb_req_t;

  // one result
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] read_byte;
    logic              line_out_valid;
    logic [BYTE_W-1:0] line_out_byte;
    logic              rx_waiting;
    logic [FILL_W-1:0] tx_fill;
    logic [FILL_W-1:0] rx_fill;
    logic              send_request;
  } utrb_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture request, read ring heads
    logic run;   // update rings, register result
  } utrb_cmd_t;

endpackage

// ===== hw/rtl/utrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// utrb_ctrl
// Controller: takes a request, runs the execute state in the datapath and
// strobes the result in the following cycle.
// ----------------------------------------------------------------------------
module utrb_ctrl
  import utrb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output logic      out_valid,
  output utrb_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath commands
  assign busy      = (state_r == ST_EXEC);
  assign out_valid = out_valid_r;
  assign cmd.load  = start && (state_r == ST_IDLE);
  assign cmd.run   = (state_r == ST_EXEC);

  // an accepted request always executes in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not enter execute");

  // execute lasts a single cycle
  a_exec_one: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("execute held longer than one cycle");

  // every execute yields exactly one result strobe
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("execute without result strobe");

endmodule

// ===== hw/rtl/utrb_dp.sv =====
// ----------------------------------------------------------------------------
// utrb_dp
// Datapath: transmit and receive ring memories, their indices and counts,
// the send enable flag and the result register.
// ----------------------------------------------------------------------------
module utrb_dp
  import utrb_pkg::*;
#(
  parameter int TX_DEPTH = TX_DEPTH_DEF,
  parameter int RX_DEPTH = RX_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  utrb_cmd_t cmd,
  input  utrb_req_t in_item,
  output utrb_rsp_t out_item
);

  localparam int TX_IW = $clog2(TX_DEPTH);
  localparam int RX_IW = $clog2(RX_DEPTH);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam logic [TX_IW-1:0] TX_LAST = TX_IW'(TX_DEPTH - 1);
  localparam logic [RX_IW-1:0] RX_LAST = RX_IW'(RX_DEPTH - 1);
  localparam logic [TX_CW-1:0] TX_FULL = TX_CW'(TX_DEPTH);
  localparam logic [RX_CW-1:0] RX_FULL = RX_CW'(RX_DEPTH);

  // ring memories
  logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
  logic [BYTE_W-1:0] rx_mem [RX_DEPTH];

  // control state
  logic [TX_IW-1:0] tx_rd_r,  tx_rd_nxt;
  logic [TX_IW-1:0] tx_wr_r,  tx_wr_nxt;
  logic [TX_CW-1:0] tx_cnt_r, tx_cnt_nxt;
  logic [RX_IW-1:0] rx_rd_r,  rx_rd_nxt;
  logic [RX_IW-1:0] rx_wr_r,  rx_wr_nxt;
  logic [RX_CW-1:0] rx_cnt_r, rx_cnt_nxt;
  logic             send_en_r, send_en_nxt;

  // captured request and head bytes
  logic [CMD_W-1:0]  cmd_r;
  logic [BYTE_W-1:0] data_r;
  logic [BYTE_W-1:0] tx_head_r;
  logic [BYTE_W-1:0] rx_head_r;

  // result
  utrb_rsp_t rsp_r;
  utrb_rsp_t rsp_nxt;

  logic tx_full;
  logic rx_full;
  logic rx_empty;
  logic can_send;
  logic tx_push;
  logic rx_push;

  assign tx_full  = (tx_cnt_r == TX_FULL);
  assign rx_full  = (rx_cnt_r == RX_FULL);
  assign rx_empty = (rx_cnt_r == '0);
  assign can_send = send_en_r && (tx_cnt_r != '0);
  assign tx_push  = cmd.run && (cmd_r == CMD_PUSH_TX) && !tx_full;
  assign rx_push  = cmd.run && (cmd_r == CMD_LINE_RX) && !rx_full;

  // command decode and next state
  always_comb begin
    tx_rd_nxt   = tx_rd_r;
    tx_wr_nxt   = tx_wr_r;
    tx_cnt_nxt  = tx_cnt_r;
    rx_rd_nxt   = rx_rd_r;
    rx_wr_nxt   = rx_wr_r;
    rx_cnt_nxt  = rx_cnt_r;
    send_en_nxt = send_en_r;
    rsp_nxt     = '0;
    case (cmd_r)
      CMD_PUSH_TX: begin
        if (tx_full) begin
          rsp_nxt.status = STAT_TX_FULL;
        end else begin
          tx_wr_nxt  = (tx_wr_r == TX_LAST) ? '0 : tx_wr_r + 1'b1;
          tx_cnt_nxt = tx_cnt_r + 1'b1;
        end
      end
      CMD_POP_RX: begin
        if (rx_empty) begin
          rsp_nxt.status = STAT_RX_EMPTY;
        end else begin
          rsp_nxt.read_byte = rx_head_r;
          rx_rd_nxt  = (rx_rd_r == RX_LAST) ? '0 : rx_rd_r + 1'b1;
          rx_cnt_nxt = rx_cnt_r - 1'b1;
        end
      end
      CMD_LINE_RX: begin
        if (rx_full) begin
          rsp_nxt.status = STAT_RX_OVFL;
        end else begin
          rx_wr_nxt  = (rx_wr_r == RX_LAST) ? '0 : rx_wr_r + 1'b1;
          rx_cnt_nxt = rx_cnt_r + 1'b1;
        end
      end
      CMD_LINE_RDY: begin
        if (can_send) begin
          rsp_nxt.line_out_valid = 1'b1;
          rsp_nxt.line_out_byte  = tx_head_r;
          tx_rd_nxt  = (tx_rd_r == TX_LAST) ? '0 : tx_rd_r + 1'b1;
          tx_cnt_nxt = tx_cnt_r - 1'b1;
        end else begin
          rsp_nxt.status = STAT_NO_SEND;
        end
      end
      CMD_SEND_EN: begin
        send_en_nxt = data_r[0];
      end
      default: begin
      end
    endcase
    rsp_nxt.rx_waiting   = (rx_cnt_nxt != '0);
    rsp_nxt.tx_fill      = FILL_W'(tx_cnt_nxt);
    rsp_nxt.rx_fill      = FILL_W'(rx_cnt_nxt);
    rsp_nxt.send_request = send_en_nxt && (tx_cnt_nxt != '0);
  end

  // ring indices, counts and send enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_rd_r   <= '0;
      tx_wr_r   <= '0;
      tx_cnt_r  <= '0;
      rx_rd_r   <= '0;
      rx_wr_r   <= '0;
      rx_cnt_r  <= '0;
      send_en_r <= 1'b1;
    end else if (cmd.run) begin
      tx_rd_r   <= tx_rd_nxt;
      tx_wr_r   <= tx_wr_nxt;
      tx_cnt_r  <= tx_cnt_nxt;
      rx_rd_r   <= rx_rd_nxt;
      rx_wr_r   <= rx_wr_nxt;
      rx_cnt_r  <= rx_cnt_nxt;
      send_en_r <= send_en_nxt;
    end
  end

  // request capture and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_item.command;
      data_r <= in_item.data_byte;
    end
    if (cmd.run) begin
      rsp_r <= rsp_nxt;
    end
  end

  // transmit ring: head read on load, write on push
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tx_head_r <= tx_mem[tx_rd_r];
    end
    if (tx_push) begin
      tx_mem[tx_wr_r] <= data_r;
    end
  end

  // receive ring: head read on load, write on line byte
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rx_head_r <= rx_mem[rx_rd_r];
    end
    if (rx_push) begin
      rx_mem[rx_wr_r] <= data_r;
    end
  end

  assign out_item = rsp_r;

  // counts never pass the ring depth
  a_tx_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    tx_cnt_r <= TX_FULL)
    else $error("transmit count above depth");

  a_rx_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    rx_cnt_r <= RX_FULL)
    else $error("receive count above depth");

  // an accepted push grows the transmit count by one
  a_tx_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    tx_push |=> (tx_cnt_r == TX_CW'($past(tx_cnt_r) + 1'b1)))
    else $error("transmit push did not advance count");

endmodule

// ===== hw/rtl/uart_tx_rx_ring_buffers_top.sv =====
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_buffers_top
// Buffered serial front end with a transmit ring and a receive ring.
//
//   channel   ports                      direction  handshake
//   request   start, busy, in_item       in         start & !busy
//   result    out_valid, out_item        out        one-cycle strobe
//
// An accepted request executes in the next cycle (busy high) and its result
// is strobed in the cycle after that. No new request is taken while busy is
// high. The ring memories are read at request accept and written in the
// execute cycle.
// A new request may be accepted in the cycle the previous result is shown.
// Reset is synchronous; rings come up empty with sending enabled.
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module uart_tx_rx_ring_buffers_top
  import utrb_pkg::*;
#(
  parameter int TX_DEPTH = TX_DEPTH_DEF,
  parameter int RX_DEPTH = RX_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  utrb_req_t in_item,
  output logic      out_valid,
  output utrb_rsp_t out_item
);

  utrb_cmd_t cmd;

  // controller
  utrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // rings and result
  utrb_dp #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the buffered serial front end. Requests go in over the
// start/busy handshake. Each accepted request is run through a local model
// of the transmit and receive rings. Every strobed result is then checked,
// field by field, against the oldest predicted result. Coverage comes from
// directed command checks, fill and drain of both rings past their limits,
// and long random traffic in fill, drain and mixed phases.
// ----------------------------------------------------------------------------
module tb;
  import utrb_pkg::*;

  localparam int TXD = TX_DEPTH_DEF;
  localparam int RXD = RX_DEPTH_DEF;
  localparam int REQ_W = $bits(utrb_req_t);

  // command codes the block ignores
  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

  localparam int MAX_PRINTS = 40;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  utrb_req_t in_item;
  logic      out_valid;
  utrb_rsp_t out_item;

  // ring model state
  logic [BYTE_W-1:0] tx_ring [TXD];
  logic [BYTE_W-1:0] rx_ring [RXD];
  int                tx_head, tx_tail, rx_head, rx_tail;
  logic [FILL_W-1:0] tx_held, rx_held;
  logic              send_on;

  utrb_rsp_t predicted_rsp_q[$];
  int        mismatch_count = 0;
  int        result_count = 0;
  int        burst_left = 0;

  uart_tx_rx_ring_buffers_top #(
    .TX_DEPTH(TXD),
    .RX_DEPTH(RXD)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // reports one field mismatch and counts it
  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      if (mismatch_count < MAX_PRINTS)
        $display("%0t: result %0d mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, result_count, what, got, want);
      mismatch_count++;
    end
  endtask

  function automatic int ring_next(input int idx, input int depth);
    return (idx == depth - 1) ? 0 : idx + 1;
  endfunction

  // ring model: one request in, one result out
  function automatic utrb_rsp_t predict_ring_step(input utrb_req_t req);
    utrb_rsp_t rsp;
    rsp = '0;
    rsp.status = STAT_OK;
    case (req.command)
      CMD_PUSH_TX: begin
        if (tx_held == FILL_W'(TXD)) begin
          rsp.status = STAT_TX_FULL;
        end else begin
          tx_ring[tx_tail] = req.data_byte;
          tx_tail = ring_next(tx_tail, TXD);
          tx_held++;
        end
      end
      CMD_POP_RX: begin
        if (rx_held == '0) begin
          rsp.status = STAT_RX_EMPTY;
        end else begin
          rsp.read_byte = rx_ring[rx_head];
          rx_head = ring_next(rx_head, RXD);
          rx_held--;
        end
      end
      CMD_LINE_RX: begin
        if (rx_held == FILL_W'(RXD)) begin
          rsp.status = STAT_RX_OVFL;
        end else begin
          rx_ring[rx_tail] = req.data_byte;
          rx_tail = ring_next(rx_tail, RXD);
          rx_held++;
        end
      end
      CMD_LINE_RDY: begin
        if (send_on && tx_held != '0) begin
          rsp.line_out_valid = 1'b1;
          rsp.line_out_byte = tx_ring[tx_head];
          tx_head = ring_next(tx_head, TXD);
          tx_held--;
        end else begin
          rsp.status = STAT_NO_SEND;
        end
      end
      CMD_SEND_EN: send_on = req.data_byte[0];
      default: ;
    endcase
    rsp.rx_waiting = (rx_held != '0);
    rsp.tx_fill = tx_held;
    rsp.rx_fill = rx_held;
    rsp.send_request = send_on && (tx_held != '0);
    return rsp;
  endfunction

  // result checker
  always @(posedge clk) begin
    utrb_rsp_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (predicted_rsp_q.size() == 0) begin
        check_field("out_valid with no result pending", out_valid, 1'b0);
      end else begin
        want = predicted_rsp_q.pop_front();
        check_field("out_valid", out_valid, 1'b1);
        check_field("status", out_item.status, want.status);
        check_field("read_byte", out_item.read_byte, want.read_byte);
        check_field("line_out_valid", out_item.line_out_valid, want.line_out_valid);
        check_field("line_out_byte", out_item.line_out_byte, want.line_out_byte);
        check_field("rx_waiting", out_item.rx_waiting, want.rx_waiting);
        check_field("tx_fill", out_item.tx_fill, want.tx_fill);
        check_field("rx_fill", out_item.rx_fill, want.rx_fill);
        check_field("send_request", out_item.send_request, want.send_request);
      end
      result_count++;
    end
  end

  // drive one request and wait until it is taken
  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic [BYTE_W-1:0] data);
    utrb_req_t req;
    req.command = cmd;
    req.data_byte = data;
    start <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy !== 1'b0);
    predicted_rsp_q.push_back(predict_ring_step(req));
  endtask

  // sender gap with junk on the request bus
  task automatic hold_off(input int cycles);
    logic [REQ_W-1:0] junk;
    repeat (cycles) begin
      junk = REQ_W'($urandom);
      start <= 1'b0;
      in_item <= junk;
      @(posedge clk);
    end
  endtask

  // bursts of random length, gaps between them unless steady
  task automatic pace_sender(input bit steady);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (!steady) hold_off($urandom_range(0, 6));
    end
    burst_left--;
  endtask

  // stop sending until every predicted result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (predicted_rsp_q.size() != 0);
  endtask

  // every command at least once, data extremes, enable bit only, ignored codes
  task automatic test_each_command();
    send_request(CMD_POP_RX, 8'hFF);    pace_sender(1'b0);
    send_request(CMD_LINE_RDY, 8'hFF);  pace_sender(1'b0);
    send_request(CMD_PUSH_TX, 8'h00);   pace_sender(1'b0);
    send_request(CMD_PUSH_TX, 8'hFF);   pace_sender(1'b0);
    send_request(CMD_SEND_EN, 8'hFE);   pace_sender(1'b0);
    send_request(CMD_LINE_RDY, 8'h00);  pace_sender(1'b0);
    send_request(CMD_PUSH_TX, 8'h5A);   pace_sender(1'b0);
    send_request(CMD_SEND_EN, 8'h01);   pace_sender(1'b0);
    repeat (4) begin
      send_request(CMD_LINE_RDY, 8'h00);
      pace_sender(1'b0);
    end
    send_request(CMD_LINE_RX, 8'h00);   pace_sender(1'b0);
    send_request(CMD_LINE_RX, 8'hFF);   pace_sender(1'b0);
    repeat (3) begin
      send_request(CMD_POP_RX, 8'h00);
      pace_sender(1'b0);
    end
    for (int c = CMD_RSVD_LO; c <= CMD_RSVD_HI; c++) begin
      send_request(CMD_W'(c), 8'($urandom));
      pace_sender(1'b0);
    end
    send_request(CMD_SEND_EN, 8'hFF);
    pace_sender(1'b0);
  endtask

  // both rings past full and back past empty
  task automatic test_ring_limits();
    send_request(CMD_SEND_EN, 8'h00);
    pace_sender(1'b0);
    repeat (TXD + 1) begin
      send_request(CMD_PUSH_TX, 8'($urandom));
      pace_sender(1'b0);
    end
    repeat (RXD + 1) begin
      send_request(CMD_LINE_RX, 8'($urandom));
      pace_sender(1'b0);
    end
    send_request(CMD_LINE_RDY, 8'($urandom));
    pace_sender(1'b0);
    send_request(CMD_SEND_EN, 8'h01);
    pace_sender(1'b0);
    repeat (TXD + 1) begin
      send_request(CMD_LINE_RDY, 8'($urandom));
      pace_sender(1'b0);
    end
    repeat (RXD + 1) begin
      send_request(CMD_POP_RX, 8'($urandom));
      pace_sender(1'b0);
    end
  endtask

  // phases biased to fill, drain or mix, with occasional full pauses
  task automatic test_random_traffic(input int target);
    int                taken;
    int                phase_len;
    int                fill_pct;
    int                pick;
    bit                steady;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data;
    taken = 0;
    while (taken < target) begin
      phase_len = $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0: fill_pct = 85;
        1: fill_pct = 15;
        default: fill_pct = 50;
      endcase
      steady = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        data = BYTE_W'($urandom_range(0, 255));
        if (pick < 4) begin
          cmd = CMD_SEND_EN;
          data[0] = ($urandom_range(0, 3) != 0);
        end else if (pick < 7) begin
          cmd = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
        end else if ($urandom_range(0, 99) < fill_pct) begin
          cmd = $urandom_range(0, 1) ? CMD_PUSH_TX : CMD_LINE_RX;
        end else begin
          cmd = $urandom_range(0, 1) ? CMD_POP_RX : CMD_LINE_RDY;
        end
        send_request(cmd, data);
        if (cmd <= CMD_SEND_EN) taken++;
        pace_sender(steady);
      end
      if ($urandom_range(0, 4) == 0) drain_results();
    end
  endtask

  // main sequence
  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    tx_head = 0;
    tx_tail = 0;
    rx_head = 0;
    rx_tail = 0;
    tx_held = '0;
    rx_held = '0;
    send_on = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_each_command();
    test_ring_limits();
    drain_results();
    test_random_traffic(1800);

    // wait out the last results, then check that none are still pending
    start <= 1'b0;
    for (int i = 0; i < 400 && predicted_rsp_q.size() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
    check_field("results still pending at end", predicted_rsp_q.size(), 0);

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== uart_tx_rx_ring_buffers_top.f =====
hw/rtl/utrb_pkg.sv
hw/rtl/utrb_ctrl.sv
hw/rtl/utrb_dp.sv
hw/rtl/uart_tx_rx_ring_buffers_top.sv
dv/tb.sv
